/* src/sce_pkg.sv */
`timescale 1ns / 1ps
// sce_pkg: shared widths, defaults, register indexes and stage control struct
// for the seam cumulative energy block. No dependencies.
package sce_pkg;

    localparam int REG_W      = 11;
    localparam int PIX_W      = 8;
    localparam int ENERGY_W   = 18;
    localparam int CFG_IDX_W  = 1;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [REG_W-1:0]    DIM_RESET  = 11'd1024;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic first_col;
        logic first_row;
        logic has_right;
    } t_nbr_ctl;

endpackage

/* src/sce_line_store.sv */
`timescale 1ns / 1ps
// sce_line_store: previous-row line memory, one write and one registered read
// per cycle. Depends on sce_pkg.
module sce_line_store import sce_pkg::*; #(
    parameter int DEPTH = DEF_MAX_WIDTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [ENERGY_W-1:0] i_wr_data,
    output logic [ENERGY_W-1:0] o_rd_data
);

    logic [ENERGY_W-1:0] r_mem [DEPTH];
    logic [ENERGY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/sce_cost.sv */
`timescale 1ns / 1ps
// sce_cost: min of up to three neighbors above plus pixel, saturating.
// Depends on sce_pkg.
module sce_cost import sce_pkg::*; (
    input  t_nbr_ctl            i_ctl,
    input  logic [PIX_W-1:0]    i_pix,
    input  logic [ENERGY_W-1:0] i_above,
    input  logic [ENERGY_W-1:0] i_left,
    input  logic [ENERGY_W-1:0] i_right,
    output logic [ENERGY_W-1:0] o_val
);

    logic [ENERGY_W-1:0] best;
    logic [ENERGY_W:0]   sum;

    always_comb begin
        best = i_above;
        if (!i_ctl.first_col && (i_left < best)) begin
            best = i_left;
        end
        if (i_ctl.has_right && (i_right < best)) begin
            best = i_right;
        end
        sum = {1'b0, best} + (ENERGY_W + 1)'(i_pix);
        if (i_ctl.first_row) begin
            o_val = ENERGY_W'(i_pix);
        end else if (sum[ENERGY_W]) begin
            o_val = ENERGY_MAX;
        end else begin
            o_val = sum[ENERGY_W-1:0];
        end
    end

endmodule

/* src/seam_cumulative_energy.sv */
`timescale 1ns / 1ps
// seam_cumulative_energy: top level, position counters, read/compute pipeline
// and output register. Depends on sce_pkg, sce_line_store, sce_cost.
//
// Takes one pixel beat per clock, sustained while the output is not stalled,
// and returns one result beat per pixel through the compute stage and output
// register. The rate is set by the line store, which does one read and one write
// per cycle: the beat entering reads the right-hand neighbor (column x+1) from
// the previous row, while the beat leaving the compute stage writes its value
// back at column x. The above and upper-left values come from registers holding
// earlier reads or, at column 0, writes; a read that hits the entry written in
// the same cycle takes the new value directly. Rows arrive bottom to top, left
// to right; image_done marks the top-right pixel. Width and height are clamped
// to 1..MAX; the user must write them only while the block is idle (unenforced).
module seam_cumulative_energy import sce_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_pixel_energy,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ENERGY_W-1:0]  o_path_energy,
    output logic                 o_image_done,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int WCW = (WW > REG_W) ? WW : REG_W;
    localparam int HCW = (HW > REG_W) ? HW : REG_W;

    logic [REG_W-1:0] r_width;
    logic [REG_W-1:0] r_height;

    logic [XW-1:0] r_col, n_col;
    logic [YW-1:0] r_row, n_row;

    logic [WCW-1:0] w_ext, w_eff, x_inc;
    logic [HCW-1:0] h_ext, h_eff, y_inc;
    logic           has_right, row_end, img_end;
    logic [XW-1:0]  rd_addr;

    logic a_fire, b_adv, out_free, fwd_hit;

    logic                r_b_vld, n_b_vld;
    logic [PIX_W-1:0]    r_b_pix;
    logic [XW-1:0]       r_b_x;
    t_nbr_ctl            r_b_ctl;
    logic                r_b_done;
    logic                r_b_fwd;
    logic [ENERGY_W-1:0] r_b_fwd_val;

    logic [ENERGY_W-1:0] r_prev_above;
    logic [ENERGY_W-1:0] r_prev_right;
    logic [ENERGY_W-1:0] r_col0;

    logic [ENERGY_W-1:0] rd_data, above, right, b_val;

    logic                r_o_vld, n_o_vld;
    logic [ENERGY_W-1:0] r_o_energy;
    logic                r_o_done;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_ext = WCW'(r_width);
        h_ext = HCW'(r_height);
        if (w_ext == '0) begin
            w_eff = WCW'(1);
        end else if (w_ext > WCW'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext == '0) begin
            h_eff = HCW'(1);
        end else if (h_ext > HCW'(MAX_HEIGHT)) begin
            h_eff = HCW'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
        x_inc     = WCW'(r_col) + WCW'(1);
        y_inc     = HCW'(r_row) + HCW'(1);
        has_right = (x_inc < w_eff);
        row_end   = !has_right;
        img_end   = row_end && (y_inc >= h_eff);
        rd_addr   = has_right ? x_inc[XW-1:0] : r_col;
    end

    // handshake
    assign out_free = !r_o_vld || !i_stall;
    assign b_adv    = r_b_vld && out_free;
    assign o_stall  = r_b_vld && !out_free;
    assign a_fire   = i_valid && !o_stall;
    assign fwd_hit  = b_adv && (r_b_x == rd_addr);

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_b_vld = r_b_vld;
        n_o_vld = r_o_vld;
        if (a_fire) begin
            if (img_end) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = r_row + YW'(1);
            end else begin
                n_col = r_col + XW'(1);
            end
        end
        if (a_fire) begin
            n_b_vld = 1'b1;
        end else if (b_adv) begin
            n_b_vld = 1'b0;
        end
        if (b_adv) begin
            n_o_vld = 1'b1;
        end else if (!i_stall) begin
            n_o_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_b_vld <= n_b_vld;
            r_o_vld <= n_o_vld;
        end
    end

    // compute stage payload
    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_pix           <= i_pixel_energy;
            r_b_x             <= r_col;
            r_b_ctl.first_col <= (r_col == '0);
            r_b_ctl.first_row <= (r_row == '0);
            r_b_ctl.has_right <= has_right;
            r_b_done          <= img_end;
            r_b_fwd           <= fwd_hit;
            r_b_fwd_val       <= b_val;
        end
    end

    sce_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (a_fire),
        .i_rd_addr (rd_addr),
        .i_wr_en   (b_adv),
        .i_wr_addr (r_b_x),
        .i_wr_data (b_val),
        .o_rd_data (rd_data)
    );

    assign above = r_b_ctl.first_col ? r_col0 : r_prev_right;
    assign right = r_b_fwd ? r_b_fwd_val : rd_data;

    sce_cost u_cost (
        .i_ctl   (r_b_ctl),
        .i_pix   (r_b_pix),
        .i_above (above),
        .i_left  (r_prev_above),
        .i_right (right),
        .o_val   (b_val)
    );

    // neighbor window and output register
    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_prev_above <= above;
            r_prev_right <= right;
            r_o_energy   <= b_val;
            r_o_done     <= r_b_done;
            if (r_b_ctl.first_col) begin
                r_col0 <= b_val;
            end
        end
    end

    assign o_valid       = r_o_vld;
    assign o_path_energy = r_o_energy;
    assign o_image_done  = r_o_done;

endmodule

/* src/sce_checker.sv */
`timescale 1ns / 1ps
// sce_checker: port-level checks for seam_cumulative_energy, bound to the top.
// Depends on sce_pkg.
module sce_checker import sce_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [ENERGY_W-1:0] o_path_energy,
    input logic                o_image_done
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_path_energy) && $stable(o_image_done)))
        else $error("stalled output beat changed");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output register");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall |=> o_valid)
        else $error("accepted beat did not reach output in two cycles");

endmodule

bind seam_cumulative_energy sce_checker u_sce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_path_energy (o_path_energy),
    .o_image_done  (o_image_done)
);

/* test/tb_seam_cumulative_energy.sv */
`timescale 1ns / 1ps
// tb_seam_cumulative_energy: self-checking testbench for the seam cumulative energy block.
// In-line energy-map predictor, queue-fed pixel driver, stalling result monitor.
// Depends on sce_pkg and seam_cumulative_energy.
module tb_seam_cumulative_energy;
    import sce_pkg::*;

    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int MAX_H         = DEF_MAX_HEIGHT;
    localparam int TALL_ROWS     = 256;
    localparam int RANDOM_PIXELS = 400;

    localparam logic [PIX_W-1:0] GRID3 [9] = '{
        8'd10,  8'd0,   8'd200,
        8'd255, 8'd255, 8'd0,
        8'd0,   8'd128, 8'd255
    };

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                done;
    } t_energy_beat;

    typedef struct {
        logic [PIX_W-1:0] pix;
        int               gap;
    } t_pixel_item;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_valid        = 1'b0;
    logic [PIX_W-1:0]     i_pixel_energy = '0;
    logic                 i_stall        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx      = CFG_IMAGE_WIDTH;
    logic [REG_W-1:0]     i_cfg_data     = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [ENERGY_W-1:0]  o_path_energy;
    logic                 o_image_done;

    seam_cumulative_energy dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_energy (i_pixel_energy),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_path_energy  (o_path_energy),
        .o_image_done   (o_image_done),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [REG_W-1:0]    model_width  = DIM_RESET;
    logic [REG_W-1:0]    model_height = DIM_RESET;
    bit [ENERGY_W-1:0]   prev_row [MAX_W];
    int unsigned         col_pos    = 0;
    int unsigned         row_pos    = 0;
    logic [ENERGY_W-1:0] left_above = '0;

    t_pixel_item  pixel_queue [$];
    t_energy_beat energy_expected [$];
    int pixels_queued = 0;
    int pixels_sent   = 0;
    int results_seen  = 0;
    int images_seen   = 0;
    int reg_writes    = 0;
    int mismatches    = 0;

    function automatic int unsigned clamp_dim(logic [REG_W-1:0] v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_energy_beat accumulate_pixel(logic [PIX_W-1:0] pix);
        int unsigned         w;
        int unsigned         h;
        int unsigned         x;
        int unsigned         y;
        int unsigned         best;
        int unsigned         sum;
        logic [ENERGY_W-1:0] above;
        logic                row_end;
        t_energy_beat        beat;
        w = clamp_dim(model_width, MAX_W);
        h = clamp_dim(model_height, MAX_H);
        x = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
        y = row_pos;
        above = prev_row[x];
        if (y == 0) begin
            sum = pix;
        end else begin
            best = above;
            if (x > 0 && left_above < best) best = left_above;
            if (x + 1 < w && prev_row[x + 1] < best) best = prev_row[x + 1];
            sum = best + pix;
            if (sum > ENERGY_MAX) sum = ENERGY_MAX;
        end
        left_above  = above;
        prev_row[x] = ENERGY_W'(sum);
        row_end     = (x + 1 >= w);
        beat.energy = ENERGY_W'(sum);
        beat.done   = row_end && (y + 1 >= h);
        if (beat.done) begin
            col_pos = 0;
            row_pos = 0;
        end else if (row_end) begin
            col_pos = 0;
            row_pos = y + 1;
        end else begin
            col_pos = x + 1;
        end
        return beat;
    endfunction

    // pixels still needed to close the current image at the current settings
    function automatic int unsigned pixels_to_image_end();
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned n;
        w = clamp_dim(model_width, MAX_W);
        h = clamp_dim(model_height, MAX_H);
        x = col_pos;
        y = row_pos;
        n = 1;
        while (!(x + 1 >= w && y + 1 >= h)) begin
            if (x + 1 >= w) begin
                x = 0;
                y++;
            end else begin
                x++;
            end
            n++;
        end
        return n;
    endfunction

    function automatic int draw_idle(int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 19);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] draw_pixel();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return PIX_W'($urandom_range(0, 7));
            3: return PIX_W'($urandom_range(248, 255));
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    always @(posedge i_clk) begin : pixel_driver
        t_pixel_item      item;
        logic             staged;
        int               staged_gap;
        logic [PIX_W-1:0] staged_pix;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            staged     = 1'b0;
            staged_gap = 0;
            staged_pix = '0;
        end else begin
            if (i_valid && !o_stall) begin
                energy_expected.push_back(accumulate_pixel(i_pixel_energy));
                pixels_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (!staged && pixel_queue.size() != 0) begin
                    item       = pixel_queue.pop_front();
                    staged     = 1'b1;
                    staged_gap = item.gap;
                    staged_pix = item.pix;
                end
                if (staged && staged_gap == 0) begin
                    i_valid        <= 1'b1;
                    i_pixel_energy <= staged_pix;
                    staged         = 1'b0;
                end else begin
                    i_valid <= 1'b0;
                    if (staged) staged_gap--;
                end
            end
        end
    end

    always @(posedge i_clk) begin : energy_monitor
        t_energy_beat want;
        int           rx_wait;
        int           rx_hold;
        int           rx_mode;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
            rx_hold = 0;
            rx_mode = 1;
        end else begin
            if (o_valid && !i_stall) begin
                if (energy_expected.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual energy %0d done %0b",
                             $time, o_path_energy, o_image_done);
                    mismatches++;
                end else begin
                    want = energy_expected.pop_front();
                    if (o_path_energy !== want.energy) begin
                        $display("%0t: path_energy expected %0d actual %0d",
                                 $time, want.energy, o_path_energy);
                        mismatches++;
                    end
                    if (o_image_done !== want.done) begin
                        $display("%0t: image_done expected %0b actual %0b",
                                 $time, want.done, o_image_done);
                        mismatches++;
                    end
                end
                results_seen++;
                if (o_image_done === 1'b1) images_seen++;
                if (results_seen % 64 == 0) rx_mode = $urandom_range(0, 2);
                // long hold-offs so the block backs up and stalls its input
                if (results_seen == 200 || results_seen == 1200) rx_hold = 150;
                rx_wait = draw_idle(rx_mode);
            end else begin
                if (rx_wait > 0) rx_wait--;
                if (rx_hold > 0) rx_hold--;
            end
            i_stall <= (rx_wait != 0) || (rx_hold != 0);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [REG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) model_width = value;
        else model_height = value;
        reg_writes++;
    endtask

    task automatic queue_pixel(logic [PIX_W-1:0] pix, int mode);
        t_pixel_item item;
        item.pix = pix;
        item.gap = draw_idle(mode);
        pixel_queue.push_back(item);
        pixels_queued++;
    endtask

    task automatic queue_run(int unsigned count, int mode);
        repeat (count) queue_pixel(draw_pixel(), mode);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pixels_sent != pixels_queued || energy_expected.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned count;
        int          directed_end;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3: each of the three neighbors wins somewhere, edges skip one
        write_reg(CFG_IMAGE_WIDTH, 11'd3);
        write_reg(CFG_IMAGE_HEIGHT, 11'd3);
        foreach (GRID3[i]) queue_pixel(GRID3[i], 1);
        wait_drained();

        // zero dims clamp to 1: every pixel is a whole image
        write_reg(CFG_IMAGE_WIDTH, 11'd0);
        write_reg(CFG_IMAGE_HEIGHT, 11'd0);
        queue_pixel(8'd255, 1);
        queue_pixel(8'd0, 1);
        queue_pixel(8'd1, 1);
        wait_drained();

        // over-range dims clamp to max; full row plus part of the next, back to back.
        // Every column is written here, so later mid-image width changes read known data.
        write_reg(CFG_IMAGE_WIDTH, 11'h7FF);
        write_reg(CFG_IMAGE_HEIGHT, 11'h7FF);
        queue_run(MAX_W + 5, 0);
        wait_drained();

        // shrink mid-image: column already past the new width ends the row
        write_reg(CFG_IMAGE_WIDTH, 11'd2);
        write_reg(CFG_IMAGE_HEIGHT, 11'd3);
        queue_run(pixels_to_image_end() + 6, 2);
        wait_drained();

        // one column, tall image at full energy: long running sums
        write_reg(CFG_IMAGE_WIDTH, 11'd1);
        write_reg(CFG_IMAGE_HEIGHT, REG_W'(TALL_ROWS));
        repeat (TALL_ROWS) queue_pixel(8'hFF, 1);
        wait_drained();

        directed_end = pixels_queued;
        while (pixels_queued - directed_end < RANDOM_PIXELS) begin
            if ($urandom_range(0, 9) < 7) begin
                // whole images, mostly small
                w = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
                h = (w > 24) ? $urandom_range(1, 3) : $urandom_range(1, 10);
                if ($urandom_range(0, 15) == 0) w = 0;
                if ($urandom_range(0, 15) == 0) h = 0;
                write_reg(CFG_IMAGE_WIDTH, REG_W'(w));
                write_reg(CFG_IMAGE_HEIGHT, REG_W'(h));
                count = pixels_to_image_end()
                      + $urandom_range(0, 1) * clamp_dim(REG_W'(w), MAX_W)
                        * clamp_dim(REG_W'(h), MAX_H);
            end else begin
                // broken sequences: settings change mid-image, short bursts
                w = ($urandom_range(0, 3) == 0) ? $urandom_range(1025, 2047) : $urandom_range(0, 30);
                h = ($urandom_range(0, 3) == 0) ? $urandom_range(1025, 2047) : $urandom_range(0, 12);
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_IMAGE_WIDTH, REG_W'(w));
                    1: write_reg(CFG_IMAGE_HEIGHT, REG_W'(h));
                    2: begin
                        write_reg(CFG_IMAGE_WIDTH, REG_W'(w));
                        write_reg(CFG_IMAGE_HEIGHT, REG_W'(h));
                    end
                    default: ;
                endcase
                count = $urandom_range(1, 40);
            end
            queue_run(count, $urandom_range(0, 2));
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("sent %0d pixels, checked %0d results, %0d images closed",
                 pixels_queued, results_seen, images_seen);
        $display("across %0d register writes incl. clamped and mid-image settings", reg_writes);
        if (mismatches == 0 && energy_expected.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
